### hw/rtl/swr_pkg.sv
// Package for the stop-and-wait receiver.
// Holds the transaction types, verdict codes and header constants.
// No dependencies.
package swr_pkg;

    localparam int unsigned HDR_BYTES = 4;
    localparam logic [7:0] FILENAME_MARK = 8'hFF;
    localparam logic [15:0] SUM_MASK = 16'hFFFF;

    localparam logic [2:0] VERDICT_ACCEPTED = 3'd0;
    localparam logic [2:0] VERDICT_DUPLICATE = 3'd1;
    localparam logic [2:0] VERDICT_CHECK_ERR = 3'd2;
    localparam logic [2:0] VERDICT_FILENAME = 3'd3;
    localparam logic [2:0] VERDICT_RUNT = 3'd4;
    localparam logic [2:0] VERDICT_AFTER_DONE = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } t_in_item;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       verdict_valid;
        logic [2:0] verdict;
        logic       ack_valid;
        logic [7:0] ack_seq;
        logic       transfer_done;
    } t_out_item;

endpackage

### hw/rtl/swr_core.sv
// Per-packet state and verdict logic of the stop-and-wait receiver.
// Steps one byte per enabled cycle and forms its result combinationally.
// Depends on swr_pkg.
module swr_core
    import swr_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result,
    output logic      o_has_result
);

    localparam int unsigned PW = $clog2(PACKET_BYTES + 1);

    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_seq, n_seq;
    logic [15:0]   r_check, n_check;
    logic [15:0]   r_sum, n_sum;
    logic          r_exp, n_exp;
    logic          r_done, n_done;

    logic [PW-1:0] count;
    logic [16:0]   sum_wide;
    logic [15:0]   sum_fold;
    logic [15:0]   calc;
    logic          in_range;
    t_out_item     res;

    always_comb begin
        in_range = (r_pos < PW'(PACKET_BYTES));
        n_seq    = r_seq;
        n_check  = r_check;
        n_sum    = r_sum;
        n_exp    = r_exp;
        n_done   = r_done;
        res      = '0;
        sum_wide = {1'b0, r_sum} + {9'd0, i_item.rx_byte};
        sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

        if (in_range) begin
            if (r_pos == PW'(0)) begin
                n_seq = i_item.rx_byte;
            end else if (r_pos == PW'(2)) begin
                n_check[7:0] = i_item.rx_byte;
            end else if (r_pos == PW'(3)) begin
                n_check[15:8] = i_item.rx_byte;
            end else if (r_pos >= PW'(HDR_BYTES)) begin
                n_sum = sum_fold;
                if (!r_done && r_seq == {7'd0, r_exp}) begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = i_item.rx_byte;
                end
            end
            count = r_pos + PW'(1);
        end else begin
            count = r_pos;
        end
        n_pos = count;
        calc  = ~n_sum & SUM_MASK;

        if (i_item.end_of_packet) begin
            res.verdict_valid = 1'b1;
            if (r_done) begin
                res.verdict = VERDICT_AFTER_DONE;
            end else if (n_seq == FILENAME_MARK) begin
                res.verdict = VERDICT_FILENAME;
            end else if (count < PW'(HDR_BYTES)) begin
                res.verdict = VERDICT_RUNT;
            end else if (calc != n_check) begin
                res.verdict = VERDICT_CHECK_ERR;
            end else if (n_seq == {7'd0, r_exp}) begin
                res.verdict   = VERDICT_ACCEPTED;
                res.ack_valid = 1'b1;
                res.ack_seq   = {7'd0, r_exp};
                n_exp         = ~r_exp;
                if (count < PW'(PACKET_BYTES)) begin
                    res.transfer_done = 1'b1;
                    n_done            = 1'b1;
                end
            end else begin
                res.verdict   = VERDICT_DUPLICATE;
                res.ack_valid = 1'b1;
                res.ack_seq   = n_seq;
            end
            n_pos = '0;
            n_sum = '0;
        end
    end

    assign o_result     = res;
    assign o_has_result = res.payload_valid | res.verdict_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_seq   <= '0;
            r_check <= '0;
            r_sum   <= '0;
            r_exp   <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_seq   <= n_seq;
            r_check <= n_check;
            r_sum   <= n_sum;
            r_exp   <= n_exp;
            r_done  <= n_done;
        end
    end

endmodule

### hw/rtl/stop_and_wait_receiver.sv
// Stop-and-wait receiver: takes one datagram byte per transaction and gives at most one
// result transaction per byte (a tentative payload byte, a packet verdict, or both). A byte can
// be taken in every cycle unless the output side stalls a byte with a result; each byte is held
// in the input register and its result is registered in the output register. The rate is set
// by the running checksum, a single 16-bit end-around-carry add per byte. Bytes that cause no
// result leave the input register without waiting for the output side.
// Depends on swr_pkg and swr_core.
module stop_and_wait_receiver
    import swr_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_out_item result;
    logic      has_result;
    logic      out_free;
    logic      advance;

    swr_core #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_in_item),
        .o_result    (result),
        .o_has_result(has_result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (out_free || !has_result);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && has_result) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_ack_has_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.ack_valid |->
            o_out_item.verdict_valid &&
            (o_out_item.verdict == VERDICT_ACCEPTED ||
             o_out_item.verdict == VERDICT_DUPLICATE))
        else $error("acknowledgement without an accepted or duplicate verdict");

    a_done_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.transfer_done |->
            o_out_item.verdict_valid && o_out_item.verdict == VERDICT_ACCEPTED &&
            o_out_item.ack_valid)
        else $error("transfer end flagged on a packet that was not accepted");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall && has_result)
        else $error("input stalled while the byte could have advanced");

    a_out_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.payload_valid || o_out_item.verdict_valid)
        else $error("empty result transaction");

endmodule

### test/testbench.sv
// Self-checking testbench for the stop-and-wait receiver: drives datagrams byte by byte with
// random idle and stall cycles and checks every result against a built-in scoreboard.
// Depends on swr_pkg and stop_and_wait_receiver.
`timescale 1ns / 100ps

module testbench
    import swr_pkg::*;
();

    localparam int unsigned PACKET_BYTES = 512;
    localparam int unsigned ITEMS = 1550;
    localparam int PERIOD_NS = 4;

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

    class receive_scoreboard;
        t_out_item   want_q[$];
        int          errors;
        int          checked;
        int          payload_seen;
        int          verdicts[6];
        int unsigned packet_bytes;
        int unsigned pos;
        logic [7:0]  seq_byte;
        logic [15:0] check_word;
        logic [16:0] payload_sum;
        logic        want_bit;
        logic        finished;

        function new(int unsigned packet_bytes_i);
            packet_bytes = packet_bytes_i;
            errors = 0;
            checked = 0;
            payload_seen = 0;
            foreach (verdicts[k]) verdicts[k] = 0;
            pos = 0;
            seq_byte = '0;
            check_word = '0;
            payload_sum = '0;
            want_bit = 1'b0;
            finished = 1'b0;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        task report(string what, int unsigned got_v, int unsigned want_v);
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got_v,
                     want_v);
            errors++;
        endtask

        // Works out the result, if any, of one accepted byte transaction.
        function void note_byte(t_in_item it);
            t_out_item r;
            logic [15:0] calc;
            r = '0;
            if (pos < packet_bytes) begin
                if (pos == 0) begin
                    seq_byte = it.rx_byte;
                end else if (pos == 2) begin
                    check_word[7:0] = it.rx_byte;
                end else if (pos == 3) begin
                    check_word[15:8] = it.rx_byte;
                end else if (pos >= HDR_BYTES) begin
                    payload_sum = payload_sum + 17'(it.rx_byte);
                    if (payload_sum > 17'h0FFFF) begin
                        payload_sum = payload_sum - 17'h0FFFF;
                    end
                    if (!finished && seq_byte == {7'd0, want_bit}) begin
                        r.payload_valid = 1'b1;
                        r.payload_byte = it.rx_byte;
                    end
                end
                pos++;
            end
            if (it.end_of_packet) begin
                calc = ~payload_sum[15:0];
                r.verdict_valid = 1'b1;
                if (finished) begin
                    r.verdict = VERDICT_AFTER_DONE;
                end else if (seq_byte == FILENAME_MARK && pos >= 1) begin
                    r.verdict = VERDICT_FILENAME;
                end else if (pos < HDR_BYTES) begin
                    r.verdict = VERDICT_RUNT;
                end else if (calc != check_word) begin
                    r.verdict = VERDICT_CHECK_ERR;
                end else if (seq_byte == {7'd0, want_bit}) begin
                    r.verdict = VERDICT_ACCEPTED;
                    r.ack_valid = 1'b1;
                    r.ack_seq = {7'd0, want_bit};
                    want_bit = ~want_bit;
                    if (pos - HDR_BYTES < packet_bytes - HDR_BYTES) begin
                        r.transfer_done = 1'b1;
                        finished = 1'b1;
                    end
                end else begin
                    r.verdict = VERDICT_DUPLICATE;
                    r.ack_valid = 1'b1;
                    r.ack_seq = seq_byte;
                end
                pos = 0;
                payload_sum = '0;
            end
            if (r.payload_valid || r.verdict_valid) begin
                want_q.push_back(r);
            end
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (want_q.size() == 0) begin
                report("result with nothing expected", got, 0);
                return;
            end
            want = want_q.pop_front();
            checked++;
            if (want.payload_valid) payload_seen++;
            if (want.verdict_valid) verdicts[want.verdict]++;
            if (got.payload_valid !== want.payload_valid)
                report("payload_valid", got.payload_valid, want.payload_valid);
            if (got.payload_byte !== want.payload_byte)
                report("payload_byte", got.payload_byte, want.payload_byte);
            if (got.verdict_valid !== want.verdict_valid)
                report("verdict_valid", got.verdict_valid, want.verdict_valid);
            if (got.verdict !== want.verdict)
                report("verdict", got.verdict, want.verdict);
            if (got.ack_valid !== want.ack_valid)
                report("ack_valid", got.ack_valid, want.ack_valid);
            if (got.ack_seq !== want.ack_seq)
                report("ack_seq", got.ack_seq, want.ack_seq);
            if (got.transfer_done !== want.transfer_done)
                report("transfer_done", got.transfer_done, want.transfer_done);
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    receive_scoreboard sb = new(PACKET_BYTES);
    logic [7:0] frame_q[$];
    int         bytes_sent = 0;
    int         frames_sent = 0;
    bit         calm = 1'b0;

    stop_and_wait_receiver #(
        .PACKET_BYTES(PACKET_BYTES)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_item(in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item(out_item)
    );

    always #(PERIOD_NS / 2) clk = ~clk;

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end

    initial begin
        forever begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall) begin
                sb.check_result(out_item);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        t_in_item it;
        bit taken;
        it.rx_byte = b;
        it.end_of_packet = last;
        calm = bytes_sent >= 350 && bytes_sent < 750;
        while (!calm && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        sb.note_byte(it);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int n;
        n = frame_q.size();
        for (int k = 0; k < n; k++) begin
            send_byte(frame_q[k], k == n - 1);
        end
        frame_q.delete();
        frames_sent++;
    endtask

    // Builds a datagram with a correct checksum unless spoil is set.
    function automatic void make_datagram(logic [7:0] seq, int n_payload, bit spoil, fill_e fill);
        int unsigned total;
        int          base;
        logic [7:0]  b;
        logic [15:0] chk;
        total = 0;
        base = frame_q.size();
        frame_q.push_back(seq);
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        for (int k = 0; k < n_payload; k++) begin
            case (fill)
                FILL_ONES: b = 8'hFF;
                FILL_ZEROS: b = 8'h00;
                default: b = 8'($urandom);
            endcase
            frame_q.push_back(b);
            if (k + HDR_BYTES < PACKET_BYTES) total += b;
        end
        while (total > 32'hFFFF) total = (total & 32'hFFFF) + (total >> 16);
        chk = ~total[15:0];
        if (spoil) chk = chk ^ 16'($urandom_range(1, 65535));
        frame_q[base + 2] = chk[7:0];
        frame_q[base + 3] = chk[15:8];
    endfunction

    initial begin
        logic       seq_bit;
        logic [7:0] dup_seq;
        int         pk;
        int         pick;
        int         n;
        seq_bit = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        frame_q.push_back(8'h00);
        send_frame();
        frame_q = '{8'h00, 8'h5A, 8'hC3};
        send_frame();
        frame_q.push_back(FILENAME_MARK);
        send_frame();
        make_datagram(8'h01, 0, 1'b0, FILL_RANDOM);
        send_frame();
        make_datagram({7'd0, seq_bit}, 3, 1'b1, FILL_ONES);
        send_frame();
        make_datagram(8'hFE, 2, 1'b0, FILL_ZEROS);
        send_frame();

        pk = 0;
        while (bytes_sent < ITEMS - 600) begin
            pk++;
            if (pk % 20 == 10) begin
                make_datagram({7'd0, seq_bit}, $urandom_range(PACKET_BYTES - HDR_BYTES,
                              PACKET_BYTES + 14), 1'b0, fill_e'($urandom_range(0, 2)));
                seq_bit = ~seq_bit;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    make_datagram({7'd0, seq_bit}, $urandom_range(0, 24), 1'b1,
                                  fill_e'($urandom_range(0, 2)));
                end else if (pick < 55) begin
                    do dup_seq = 8'($urandom_range(0, 254));
                    while (dup_seq == {7'd0, seq_bit});
                    make_datagram(dup_seq, $urandom_range(0, 24), $urandom_range(0, 3) == 0,
                                  fill_e'($urandom_range(0, 2)));
                end else if (pick < 70) begin
                    make_datagram(FILENAME_MARK, $urandom_range(0, 20), $urandom_range(0, 1),
                                  FILL_RANDOM);
                end else begin
                    n = (pick < 82) ? $urandom_range(1, 3) : $urandom_range(1, 30);
                    for (int k = 0; k < n; k++) frame_q.push_back(8'($urandom));
                end
            end
            send_frame();
        end

        // A short in-order packet ends the transfer; later packets only get a verdict.
        case ($urandom_range(0, 2))
            0: n = 0;
            1: n = $urandom_range(1, 60);
            default: n = PACKET_BYTES - HDR_BYTES - 1;
        endcase
        make_datagram({7'd0, seq_bit}, n, 1'b0, FILL_RANDOM);
        send_frame();
        seq_bit = ~seq_bit;
        make_datagram({7'd0, seq_bit}, 6, 1'b0, FILL_RANDOM);
        send_frame();
        make_datagram(FILENAME_MARK, 2, 1'b0, FILL_RANDOM);
        send_frame();
        frame_q.push_back(8'h00);
        send_frame();

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes in %0d datagrams; checked %0d results, %0d with payload.",
                 bytes_sent, frames_sent, sb.checked, sb.payload_seen);
        $display({"Verdicts: %0d accepted, %0d duplicate, %0d checksum error, ",
                  "%0d filename, %0d runt, %0d after done."},
                 sb.verdicts[VERDICT_ACCEPTED], sb.verdicts[VERDICT_DUPLICATE],
                 sb.verdicts[VERDICT_CHECK_ERR], sb.verdicts[VERDICT_FILENAME],
                 sb.verdicts[VERDICT_RUNT], sb.verdicts[VERDICT_AFTER_DONE]);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results still expected.", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
